>>> rtl/wmvd_pkg.sv
// ----------------------------------------------------------------------------
// wmvd_pkg
// Shared types and constants of the windowed depth median block.
// ----------------------------------------------------------------------------
package wmvd_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_MAX_RADIUS = 7;

   localparam int DEPTH_W  = 16;
   localparam int SCALE_W  = 20;
   localparam int MEDIAN_W = 36;
   localparam int COORD_W  = 10;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_RADIUS = 2'd2;
   localparam logic [1:0] REG_SCALE  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLIP,
      ST_GATHER,
      ST_GWAIT,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_PICK,
      ST_PICK_WAIT,
      ST_MUL,
      ST_DONE
   } state_type;

   // compare unit operands
   typedef struct packed {
      logic [DEPTH_W-1:0] a;
      logic [DEPTH_W-1:0] b;
   } cmp_req_type;

endpackage

>>> rtl/wmvd_ram.sv
// ----------------------------------------------------------------------------
// wmvd_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wmvd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> rtl/window_median_valid_depth.sv
// ----------------------------------------------------------------------------
// window_median_valid_depth
// Median of the non-zero depth pixels in a clipped square window.
// ----------------------------------------------------------------------------
// A write request (action 0) stores one raw pixel; writes can follow back to
// back. A query request (action 1) clips a window of the configured radius to
// the frame, walks it pixel by pixel through the frame RAM read port, keeps the
// non-zero pixels in a small window RAM, sorts them with an insertion sort that
// does one compare/move per cycle through the window RAM port, and finally
// multiplies the median by depth_scale. For n valid pixels the sort makes at
// most n*(n-1)/2 moves, which dominate the work at radius 7 with every pixel
// valid. The block accepts nothing while a query is in work. One result per
// query, none per write; a finished result waits in the output register,
// writes are still accepted meanwhile, and the next query waits in its last
// cycle until that register is free.
module window_median_valid_depth #(
   parameter int MAX_WIDTH  = wmvd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = wmvd_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = wmvd_pkg::DEF_MAX_RADIUS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // action
   input  logic [55:0] req_tdata,   // pixel_index, raw_depth, query_x, query_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,   // found
   output logic [39:0] rsp_tdata,   // median_depth
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import wmvd_pkg::*;

   localparam int STORE   = MAX_WIDTH * MAX_HEIGHT;
   localparam int SA_W    = (STORE > 1) ? $clog2(STORE) : 1;
   localparam int SIDE    = 2 * MAX_RADIUS + 1;
   localparam int WIN     = SIDE * SIDE;
   localparam int WA_W    = (WIN > 1) ? $clog2(WIN) : 1;
   localparam int CNT_W   = $clog2(WIN + 1);
   localparam int XW      = 14;  // signed coordinate math width
   localparam int RW      = $clog2(MAX_RADIUS + 1) + 1;

   // ---------------- configuration ----------------
   logic [8:0]         width_ff, height_ff;
   logic [2:0]         radius_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         radius_ff <= 3'd2;
         scale_ff  <= SCALE_W'(65536);
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_WIDTH:  width_ff  <= csr_pwdata[8:0];
            REG_HEIGHT: height_ff <= csr_pwdata[8:0];
            REG_RADIUS: radius_ff <= csr_pwdata[2:0];
            REG_SCALE:  scale_ff  <= csr_pwdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_WIDTH:  csr_prdata = {23'd0, width_ff};
         REG_HEIGHT: csr_prdata = {23'd0, height_ff};
         REG_RADIUS: csr_prdata = {29'd0, radius_ff};
         REG_SCALE:  csr_prdata = {12'd0, scale_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   // ---------------- input fields ----------------
   logic [15:0]        in_index, in_raw;
   logic signed [COORD_W-1:0] in_qx, in_qy;
   assign in_index = req_tdata[15:0];
   assign in_raw   = req_tdata[31:16];
   assign in_qx    = req_tdata[41:32];
   assign in_qy    = req_tdata[51:42];

   // effective (saturated) geometry
   logic signed [XW-1:0] w_eff, h_eff, r_eff;
   assign w_eff = (32'(width_ff) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(width_ff);
   assign h_eff = (32'(height_ff) > MAX_HEIGHT) ? XW'(MAX_HEIGHT) : XW'(height_ff);
   assign r_eff = (32'(radius_ff) > MAX_RADIUS) ? XW'(MAX_RADIUS) : XW'(radius_ff);

   // ---------------- state ----------------
   state_type state_ff, state_in;
   logic signed [XW-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic signed [XW-1:0] left_ff, left_in, right_ff, right_in;
   logic signed [XW-1:0] bot_ff, bot_in;
   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic [SA_W+1:0]      row_ff, row_in;      // y * width
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     i_ff, i_in, j_ff, j_in;
   logic [DEPTH_W-1:0]   key_ff, key_in, mid_ff, mid_in;
   logic [DEPTH_W:0]     msum_ff, msum_in;
   logic [7:0]           vcount_ff, vcount_in;
   logic [DEPTH_W-1:0]   prefix_ff, prefix_in;
   logic                 rv_ff, rv_in, rfound_ff, rfound_in;
   logic [MEDIAN_W-1:0]  rmed_ff, rmed_in;

   // frame RAM
   logic               f_we;
   logic [SA_W-1:0]    f_waddr, f_raddr;
   logic [DEPTH_W-1:0] f_rdata;
   logic [SA_W+1:0]    gidx;

   // window RAM
   logic               w_we;
   logic [WA_W-1:0]    w_waddr, w_raddr;
   logic [DEPTH_W-1:0] w_wdata, w_rdata;

   wmvd_ram #(.WIDTH(DEPTH_W), .DEPTH(STORE)) u_frame (
      .clock(clock), .wr_en(f_we), .wr_addr(f_waddr), .wr_data(in_raw),
      .rd_addr(f_raddr), .rd_data(f_rdata));

   wmvd_ram #(.WIDTH(DEPTH_W), .DEPTH(WIN)) u_win (
      .clock(clock), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(w_wdata),
      .rd_addr(w_raddr), .rd_data(w_rdata));

   logic in_acc, out_acc;
   assign req_tready = (state_ff == ST_IDLE);
   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;

   assign f_we    = in_acc && (req_tuser == ACT_WRITE) && (32'(in_index) < STORE);
   assign f_waddr = SA_W'(in_index);
   assign gidx    = row_ff + (SA_W+2)'(x_ff);

   // compare unit: window value above key
   cmp_req_type cmp;
   logic        cmp_gt;
   assign cmp.a  = w_rdata;
   assign cmp.b  = key_ff;
   assign cmp_gt = cmp.a > cmp.b;

   // median scale multiply (registered inputs: msum_ff and scale_ff)
   logic [DEPTH_W+SCALE_W:0] prod;
   assign prod = (DEPTH_W+SCALE_W+1)'(msum_ff) * (DEPTH_W+SCALE_W+1)'(scale_ff);

   logic signed [XW-1:0] t_l, t_r, t_t, t_b;

   always_comb begin
      state_in  = state_ff;
      qx_in = qx_ff; qy_in = qy_ff;
      left_in = left_ff; right_in = right_ff; bot_in = bot_ff;
      x_in = x_ff; y_in = y_ff; row_in = row_ff;
      n_in = n_ff; i_in = i_ff; j_in = j_ff;
      key_in = key_ff; mid_in = mid_ff; msum_in = msum_ff;
      vcount_in = vcount_ff; prefix_in = prefix_ff;
      rv_in = rv_ff; rfound_in = rfound_ff; rmed_in = rmed_ff;
      f_raddr = gidx[SA_W-1:0];
      w_we = 1'b0; w_waddr = WA_W'(n_ff); w_wdata = f_rdata;
      w_raddr = WA_W'(j_ff - 1'b1);
      t_l = qx_ff - r_eff; t_r = qx_ff + r_eff;
      t_t = qy_ff - r_eff; t_b = qy_ff + r_eff;
      if (t_l < 0) t_l = '0;
      if (t_r > w_eff - 1) t_r = w_eff - 1;
      if (t_t < 0) t_t = '0;
      if (t_b > h_eff - 1) t_b = h_eff - 1;

      if (out_acc) rv_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (in_acc && req_tuser == ACT_QUERY) begin
               qx_in = XW'(in_qx);
               qy_in = XW'(in_qy);
               state_in = ST_CLIP;
            end
         end
         ST_CLIP: begin
            left_in = t_l; right_in = t_r; bot_in = t_b;
            x_in = t_l; y_in = t_t;
            row_in = (SA_W+2)'(t_t) * (SA_W+2)'(w_eff);
            n_in = '0;
            if (width_ff == 9'd0 || height_ff == 9'd0 || scale_ff == '0 ||
                t_l > t_r || t_t > t_b) begin
               state_in = ST_DONE;   // not found, n stays zero
            end else begin
               state_in = ST_GATHER;
            end
         end
         ST_GATHER: begin
            state_in = ST_GWAIT;  // read issued at gidx
         end
         ST_GWAIT: begin
            if (f_rdata != '0) begin
               w_we = 1'b1;
               n_in = n_ff + 1'b1;
            end
            if (x_ff == right_ff) begin
               x_in = left_ff;
               y_in = y_ff + XW'(1);
               row_in = row_ff + (SA_W+2)'(w_eff);
               if (y_ff == bot_ff) begin
                  state_in = ST_SORT_RD;
                  i_in = CNT_W'(1);
               end else begin
                  state_in = ST_GATHER;
               end
            end else begin
               x_in = x_ff + XW'(1);
               state_in = ST_GATHER;
            end
            if (state_in == ST_SORT_RD) begin
               vcount_in = 8'(n_in);
               if (n_in == '0) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SORT_RD: begin
            // fetch key = win[i]
            w_raddr = WA_W'(i_ff);
            if (i_ff >= n_ff) begin
               state_in = ST_PICK;
               w_raddr = WA_W'(n_ff >> 1);
            end else begin
               j_in = i_ff;
               state_in = ST_SORT_CMP;
               key_in = '0;
            end
         end
         ST_SORT_CMP: begin
            // first cycle after SORT_RD: key arrives; later: win[j-1] arrives
            if (key_ff == '0) begin
               key_in = w_rdata;   // valid values are nonzero
               w_raddr = WA_W'(j_ff - 1'b1);
            end else if (j_ff != '0 && cmp_gt) begin
               w_we = 1'b1; w_waddr = WA_W'(j_ff); w_wdata = w_rdata;
               j_in = j_ff - 1'b1;
               w_raddr = WA_W'(j_ff - 2'd2);
            end else begin
               w_we = 1'b1; w_waddr = WA_W'(j_ff); w_wdata = key_ff;
               i_in = i_ff + 1'b1;
               state_in = ST_SORT_RD;
            end
         end
         ST_PICK: begin
            // upper middle (the median for an odd count) arrives; fetch lower
            mid_in = w_rdata;
            w_raddr = WA_W'((n_ff >> 1) - 1'b1);
            state_in = ST_PICK_WAIT;
         end
         ST_PICK_WAIT: begin
            // keep the lower middle on the read port for MUL
            w_raddr = WA_W'((n_ff >> 1) - 1'b1);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (n_ff[0]) begin
               msum_in = {1'b0, mid_ff};
            end else begin
               msum_in = (DEPTH_W+1)'(mid_ff) + (DEPTH_W+1)'(w_rdata);
               prefix_in = w_rdata;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rv_ff || out_acc) begin
               rv_in = 1'b1;
               if (n_ff == '0) begin
                  rfound_in = 1'b0;
                  rmed_in = '0;
               end else begin
                  rfound_in = 1'b1;
                  rmed_in = n_ff[0] ? MEDIAN_W'(prod) : MEDIAN_W'(prod >> 1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rv_ff     <= 1'b0;
         vcount_ff <= '0;
         prefix_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rv_ff     <= rv_in;
         vcount_ff <= vcount_in;
         prefix_ff <= prefix_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff <= qx_in; qy_ff <= qy_in;
      left_ff <= left_in; right_ff <= right_in; bot_ff <= bot_in;
      x_ff <= x_in; y_ff <= y_in; row_ff <= row_in;
      n_ff <= n_in; i_ff <= i_in; j_ff <= j_in;
      key_ff <= key_in; mid_ff <= mid_in; msum_ff <= msum_in;
      rfound_ff <= rfound_in; rmed_ff <= rmed_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = rfound_ff;
   assign rsp_tdata  = {4'd0, rmed_ff};

   // ---------------- assertions ----------------
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("ready while query in work");
   a_nf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rmed_ff == '0))
      else $error("not found result carries depth");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT_CMP) |-> (n_ff <= CNT_W'(WIN)))
      else $error("window count overflow");

endmodule
